// ===== rtl/rlp_pkg.sv =====
package rlp_pkg;

   localparam int ADDR_BITS    = 16;
   localparam int MEM_DEPTH    = 1 << ADDR_BITS;
   localparam int REF_ENTRIES  = 22;
   localparam int REF_IDX_BITS = $clog2(REF_ENTRIES);
   // wide enough for base + offset carry at any address width
   localparam int WIDE_W       = (ADDR_BITS > 17) ? ADDR_BITS : 17;

   localparam int CMD_W   = 3;
   localparam int OFS_W   = 16;
   localparam int BYTE_W  = 8;
   localparam int NIB_W   = 3;
   localparam int REFI_W  = 8;
   localparam int VAL_W   = 16;
   localparam int ACC_W   = 32;

   localparam logic [CMD_W-1:0] CMD_START  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SETREF = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_MODIFY = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_BAD_REF = 1'b1;

   typedef logic [ADDR_BITS-1:0] addr_type;

   // controller -> datapath
   typedef struct packed {
      logic       accept;
      logic       rd_en;
      logic       calc;
      logic       wr_en;
      logic [1:0] byte_idx;
      logic       out_load;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       patch_go;
      logic [1:0] last_byte;
   } dp_stat_type;

   // low nib nibbles set
   function automatic logic [ACC_W-1:0] nib_mask(input logic [NIB_W-1:0] nib);
      logic [ACC_W-1:0] m;
      begin
         case (nib)
            3'd1:    m = 32'h0000_000F;
            3'd2:    m = 32'h0000_00FF;
            3'd3:    m = 32'h0000_0FFF;
            3'd4:    m = 32'h0000_FFFF;
            3'd5:    m = 32'h000F_FFFF;
            3'd6:    m = 32'h00FF_FFFF;
            3'd7:    m = 32'h0FFF_FFFF;
            default: m = 32'h0000_0000;
         endcase
         return m;
      end
   endfunction

endpackage

// ===== rtl/rlp_if.sv =====
interface rlp_req_if import rlp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [OFS_W-1:0]  offset;
   logic [BYTE_W-1:0] data_byte;
   logic [NIB_W-1:0]  half_bytes;
   logic              subtract;
   logic [REFI_W-1:0] ref_index;
   logic [VAL_W-1:0]  value;

   modport source(output valid, cmd, offset, data_byte, half_bytes, subtract, ref_index,
                  value, input ready);
   modport sink(input valid, cmd, offset, data_byte, half_bytes, subtract, ref_index,
                value, output ready);
endinterface

interface rlp_rsp_if import rlp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              status;
   logic [BYTE_W-1:0] read_data;

   modport source(output valid, status, read_data, input ready);
   modport sink(input valid, status, read_data, output ready);
endinterface

// ===== rtl/rlp_datapath.sv =====
module rlp_datapath import rlp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [OFS_W-1:0]  req_offset,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic [NIB_W-1:0]  req_half_bytes,
   input  logic              req_subtract,
   input  logic [REFI_W-1:0] req_ref_index,
   input  logic [VAL_W-1:0]  req_value,
   input  ctrl_cmd_type      ctrl,
   output dp_stat_type       stat,
   output logic              rsp_status,
   output logic [BYTE_W-1:0] rsp_read_data
);

   logic [BYTE_W-1:0] load_mem [0:MEM_DEPTH-1];
   logic [BYTE_W-1:0] mem_rd_ff;

   logic [VAL_W-1:0]  base_ff, base_in;
   logic              mode_ff, mode_in;
   logic [VAL_W-1:0]  ref_ff [REF_ENTRIES];

   addr_type          addr_ff;
   logic [VAL_W-1:0]  operand_ff;
   logic              sub_ff;
   logic [NIB_W-1:0]  nib_ff;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  res_ff;
   logic              capture_ff;
   logic              pend_status_ff;
   logic              pend_read_ff;
   logic              out_status_ff;
   logic [BYTE_W-1:0] out_data_ff;

   logic [WIDE_W-1:0]       rel_wide;
   logic [WIDE_W-1:0]       abs_wide;
   addr_type                rel_addr;
   addr_type                abs_addr;
   addr_type                walk_addr;
   logic                    ref_ok;
   logic [REF_IDX_BITS-1:0] ref_idx;
   logic                    bad_ref;
   logic                    ref_we;
   logic [REF_IDX_BITS-1:0] ref_wa;
   logic                    mem_we;
   logic                    mem_re;
   addr_type                mem_addr;
   logic [BYTE_W-1:0]       mem_wd;
   logic [ACC_W-1:0]        sum;
   logic [ACC_W-1:0]        mask;
   logic [1:0]              byte_sel;
   logic [NIB_W-1:0]        nib_m1;

   assign rel_wide  = WIDE_W'(base_ff) + WIDE_W'(req_offset);
   assign abs_wide  = WIDE_W'(req_offset);
   assign rel_addr  = rel_wide[ADDR_BITS-1:0];
   assign abs_addr  = abs_wide[ADDR_BITS-1:0];
   assign walk_addr = addr_ff + ADDR_BITS'(ctrl.byte_idx);

   assign ref_ok  = (req_ref_index != '0) && (9'(req_ref_index) < 9'(REF_ENTRIES));
   assign ref_idx = req_ref_index[REF_IDX_BITS-1:0];

   assign stat.patch_go = (req_cmd == CMD_MODIFY) && (req_half_bytes != '0) &&
                          !(mode_ff && !ref_ok);
   assign nib_m1         = nib_ff - 3'd1;
   assign stat.last_byte = nib_m1[2:1];

   assign sum      = sub_ff ? acc_ff - ACC_W'(operand_ff) : acc_ff + ACC_W'(operand_ff);
   assign mask     = nib_mask(nib_ff);
   // first byte goes out first: most significant end of the result
   assign byte_sel = stat.last_byte - ctrl.byte_idx;

   always_comb begin
      base_in = base_ff;
      mode_in = mode_ff;
      ref_we  = 1'b0;
      ref_wa  = ref_idx;
      bad_ref = 1'b0;
      mem_we  = 1'b0;
      mem_re  = 1'b0;
      mem_addr = walk_addr;
      mem_wd  = res_ff[8*byte_sel +: 8];
      if (ctrl.accept) begin
         case (req_cmd)
            CMD_START: begin
               base_in = req_value;
               ref_we  = 1'b1;
               ref_wa  = REF_IDX_BITS'(1);
               mode_in = 1'b0;
            end
            CMD_SETREF: begin
               if (ref_ok) begin
                  ref_we  = 1'b1;
                  mode_in = 1'b1;
               end else begin
                  bad_ref = 1'b1;
               end
            end
            CMD_WRITE: begin
               mem_we   = 1'b1;
               mem_addr = rel_addr;
               mem_wd   = req_data_byte;
            end
            CMD_MODIFY: begin
               bad_ref = mode_ff && !ref_ok;
            end
            CMD_READ: begin
               mem_re   = 1'b1;
               mem_addr = abs_addr;
            end
            default: begin
            end
         endcase
      end else if (ctrl.rd_en) begin
         mem_re = 1'b1;
      end else if (ctrl.wr_en) begin
         mem_we = 1'b1;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.accept) begin
         acc_in = '0;
      end else if (capture_ff) begin
         acc_in = {acc_ff[ACC_W-BYTE_W-1:0], mem_rd_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         load_mem[mem_addr] <= mem_wd;
      end
      if (mem_re) begin
         mem_rd_ff <= load_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         mode_ff    <= 1'b0;
         capture_ff <= 1'b0;
         for (int i = 0; i < REF_ENTRIES; i++) begin
            ref_ff[i] <= '0;
         end
      end else begin
         base_ff    <= base_in;
         mode_ff    <= mode_in;
         capture_ff <= ctrl.rd_en;
         if (ref_we) begin
            ref_ff[ref_wa] <= req_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctrl.accept) begin
         addr_ff        <= rel_addr;
         operand_ff     <= mode_ff ? ref_ff[ref_idx] : req_value;
         sub_ff         <= req_subtract;
         nib_ff         <= req_half_bytes;
         pend_status_ff <= bad_ref;
         pend_read_ff   <= (req_cmd == CMD_READ);
      end
      if (ctrl.calc) begin
         // odd counts keep the high nibble of the first byte
         res_ff <= (acc_ff & ~mask) | (sum & mask);
      end
      if (ctrl.out_load) begin
         out_status_ff <= pend_status_ff ? STATUS_BAD_REF : STATUS_OK;
         out_data_ff   <= pend_read_ff ? mem_rd_ff : '0;
      end
   end

   assign rsp_status    = out_status_ff;
   assign rsp_read_data = out_data_ff;

endmodule

// ===== rtl/rlp_ctrl.sv =====
module rlp_ctrl import rlp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type ctrl
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_WAIT = 3'd2;
   localparam logic [2:0] S_CALC = 3'd3;
   localparam logic [2:0] S_WR   = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_FIN) && out_free);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ctrl.accept   = accept;
      ctrl.rd_en    = 1'b0;
      ctrl.calc     = 1'b0;
      ctrl.wr_en    = 1'b0;
      ctrl.byte_idx = cnt_ff;
      ctrl.out_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = stat.patch_go ? S_RD : S_FIN;
               cnt_in   = '0;
            end
         end
         S_RD: begin
            ctrl.rd_en = 1'b1;
            if (cnt_ff == stat.last_byte) begin
               state_in = S_WAIT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 2'd1;
            end
         end
         S_WAIT: begin
            // last byte lands in the accumulator here
            state_in = S_CALC;
         end
         S_CALC: begin
            ctrl.calc = 1'b1;
            state_in  = S_WR;
         end
         S_WR: begin
            ctrl.wr_en = 1'b1;
            if (cnt_ff == stat.last_byte) begin
               state_in = S_FIN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 2'd1;
            end
         end
         S_FIN: begin
            if (out_free) begin
               ctrl.out_load = 1'b1;
               if (accept) begin
                  state_in = stat.patch_go ? S_RD : S_FIN;
                  cnt_in   = '0;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_rd_progress: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |=> (state_ff == S_RD || state_ff == S_WAIT))
      else $error("read loop left early");

   a_wr_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR && cnt_ff == stat.last_byte) |=> (state_ff == S_FIN))
      else $error("write loop did not finish");

   a_simple_cmd: assert property (@(posedge clock) disable iff (reset)
      (accept && !stat.patch_go) |=> (state_ff == S_FIN))
      else $error("single-cycle word not finished");
`endif

endmodule

// ===== rtl/relocating_load_and_patch.sv =====
// Relocating load-and-patch engine: applies decoded loader words to a byte memory.
// req channel: one word per command (start section, set reference, write byte,
//   modify, read byte), accepted when valid and ready are both high.
// rsp channel: exactly one result word per request word, in order, carrying a
//   status bit (bad reference index) and the byte read by a read-byte command.
// Throughput: start, set reference, write, read and a modify with zero nibbles
//   or a bad reference are taken back to back while the rsp side keeps up.
//   A modify covering n bytes (n = 1..4) holds off the next word through n
//   reads, a wait for the last read to land, an add/mask step, n writes and
//   the step that loads the result.
// The result word is loaded into the rsp register from S_FIN, which follows
//   acceptance of a simple word, or the last patch write for a modify.
// A finished result sits in the rsp register; the engine keeps accepting and
//   working on the next word and only stalls when a second result is ready
//   while the first is still not taken.
// Reset (synchronous) clears section base, reference table, reference mode and
//   all control; memory contents are undefined until written.
module relocating_load_and_patch import rlp_pkg::*; (
   input logic       clock,
   input logic       reset,
   rlp_req_if.sink   req,
   rlp_rsp_if.source rsp
);

   ctrl_cmd_type ctrl;
   dp_stat_type  stat;

   rlp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   rlp_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req.cmd),
      .req_offset     (req.offset),
      .req_data_byte  (req.data_byte),
      .req_half_bytes (req.half_bytes),
      .req_subtract   (req.subtract),
      .req_ref_index  (req.ref_index),
      .req_value      (req.value),
      .ctrl           (ctrl),
      .stat           (stat),
      .rsp_status     (rsp.status),
      .rsp_read_data  (rsp.read_data)
   );

endmodule

// ===== dv/relocating_load_and_patch_tb.sv =====
`timescale 1ns / 1ps

module relocating_load_and_patch_tb import rlp_pkg::*; ();

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 5;
   localparam int RANDOM_WORDS = 1350;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RECENT_MAX   = 64;
   localparam int N_DIRECTED   = 26;

   localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [OFS_W-1:0]  offset;
      logic [BYTE_W-1:0] data_byte;
      logic [NIB_W-1:0]  half_bytes;
      logic              subtract;
      logic [REFI_W-1:0] ref_index;
      logic [VAL_W-1:0]  value;
   } load_word_type;

   typedef struct packed {
      logic              status;
      logic [BYTE_W-1:0] read_data;
   } result_word_type;

   typedef struct packed {
      load_word_type   word;
      logic            fixed;
      result_word_type result;
   } stim_row_type;

   // fixed = 1: result typed in the row; fixed = 0: result comes from the predictor
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      '{'{CMD_START,  16'h0000, 8'h00, 3'd0, 1'b0, 8'h00, 16'h1000}, 1'b1, '{STATUS_OK, 8'h00}},
      '{'{CMD_WRITE,  16'h0000, 8'h12, 3'd0, 1'b0, 8'h00, 16'h0000}, 1'b1, '{STATUS_OK, 8'h00}},
      '{'{CMD_WRITE,  16'h0001, 8'h34, 3'd0, 1'b0, 8'h00, 16'h0000}, 1'b1, '{STATUS_OK, 8'h00}},
      '{'{CMD_WRITE,  16'h0002, 8'h00, 3'd0, 1'b0, 8'h00, 16'h0000}, 1'b1, '{STATUS_OK, 8'h00}},
      '{'{CMD_WRITE,  16'h0003, 8'hFF, 3'd0, 1'b0, 8'h00, 16'h0000}, 1'b1, '{STATUS_OK, 8'h00}},
      '{'{CMD_READ,   16'h1000, 8'h00, 3'd0, 1'b0, 8'h00, 16'h0000}, 1'b1, '{STATUS_OK, 8'h12}},
      // value mode: ref_index is don't-care
      '{'{CMD_MODIFY, 16'h0000, 8'h00, 3'd5, 1'b0, 8'hFF, 16'hFFFF}, 1'b0, '{STATUS_OK, 8'h00}},
      '{'{CMD_READ,   16'h1000, 8'h00, 3'd0, 1'b0, 8'h00, 16'h0000}, 1'b0, '{STATUS_OK, 8'h00}},
      '{'{CMD_SETREF, 16'h0000, 8'h00, 3'd0, 1'b0, 8'h00, 16'h1234}, 1'b1,
        '{STATUS_BAD_REF, 8'h00}},
      '{'{CMD_SETREF, 16'h0000, 8'h00, 3'd0, 1'b0, 8'd22, 16'h1234}, 1'b1,
        '{STATUS_BAD_REF, 8'h00}},
      '{'{CMD_SETREF, 16'h0000, 8'h00, 3'd0, 1'b0, 8'hFF, 16'h1234}, 1'b1,
        '{STATUS_BAD_REF, 8'h00}},
      '{'{CMD_SETREF, 16'h0000, 8'h00, 3'd0, 1'b0, 8'd21, 16'hFFFF}, 1'b1, '{STATUS_OK, 8'h00}},
      '{'{CMD_MODIFY, 16'h0000, 8'h00, 3'd6, 1'b1, 8'd21, 16'h0000}, 1'b0, '{STATUS_OK, 8'h00}},
      '{'{CMD_MODIFY, 16'h0000, 8'h00, 3'd4, 1'b0, 8'h00, 16'h0000}, 1'b1,
        '{STATUS_BAD_REF, 8'h00}},
      '{'{CMD_MODIFY, 16'h0000, 8'h00, 3'd7, 1'b0, 8'd1,  16'h0000}, 1'b0, '{STATUS_OK, 8'h00}},
      // zero nibbles touches nothing, so an unwritten target is fine
      '{'{CMD_MODIFY, 16'hFFFF, 8'h00, 3'd0, 1'b0, 8'd1,  16'h0000}, 1'b1, '{STATUS_OK, 8'h00}},
      '{'{CMD_SPARE5, 16'hFFFF, 8'hFF, 3'd7, 1'b1, 8'hFF, 16'hFFFF}, 1'b1, '{STATUS_OK, 8'h00}},
      '{'{CMD_SPARE7, 16'h1000, 8'hFF, 3'd7, 1'b1, 8'h00, 16'hFFFF}, 1'b1, '{STATUS_OK, 8'h00}},
      '{'{CMD_START,  16'h0000, 8'h00, 3'd0, 1'b0, 8'h00, 16'hFFFF}, 1'b1, '{STATUS_OK, 8'h00}},
      '{'{CMD_WRITE,  16'h0000, 8'hA5, 3'd0, 1'b0, 8'h00, 16'h0000}, 1'b1, '{STATUS_OK, 8'h00}},
      '{'{CMD_WRITE,  16'h0001, 8'h5A, 3'd0, 1'b0, 8'h00, 16'h0000}, 1'b1, '{STATUS_OK, 8'h00}},
      '{'{CMD_WRITE,  16'hFFFF, 8'hC3, 3'd0, 1'b0, 8'h00, 16'h0000}, 1'b1, '{STATUS_OK, 8'h00}},
      // patch straddles the top of memory
      '{'{CMD_MODIFY, 16'hFFFF, 8'h00, 3'd6, 1'b0, 8'h00, 16'hFFFF}, 1'b0, '{STATUS_OK, 8'h00}},
      '{'{CMD_MODIFY, 16'h0000, 8'h00, 3'd1, 1'b1, 8'h00, 16'h0001}, 1'b0, '{STATUS_OK, 8'h00}},
      '{'{CMD_READ,   16'h0000, 8'h00, 3'd0, 1'b0, 8'h00, 16'h0000}, 1'b0, '{STATUS_OK, 8'h00}},
      '{'{CMD_READ,   16'hFFFF, 8'h00, 3'd0, 1'b0, 8'h00, 16'h0000}, 1'b0, '{STATUS_OK, 8'h00}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   rlp_req_if req_if ();
   rlp_rsp_if rsp_if ();

   relocating_load_and_patch u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   always #HALF_PERIOD clock = ~clock;

   // predictor state
   bit   [BYTE_W-1:0] image_mem   [MEM_DEPTH];
   bit                image_valid [MEM_DEPTH];
   logic [VAL_W-1:0]  section_base;
   logic [VAL_W-1:0]  ref_table   [REF_ENTRIES];
   logic              ref_mode;

   result_word_type pending_results [$];
   addr_type        recent_addrs [$];
   int              cmd_count [8];
   int              words_sent;
   int              results_seen;
   int              fails;
   int              cycles;
   bit              src_calm;
   bit              sink_calm;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_results.size());
         $display("** relocating_load_and_patch: FAILED **");
         $finish;
      end
   end

   function automatic bit ref_ok(input logic [REFI_W-1:0] idx);
      return (int'(idx) >= 1) && (int'(idx) < REF_ENTRIES);
   endfunction

   task automatic store_byte(input addr_type a, input logic [BYTE_W-1:0] d);
      image_mem[a]   = d;
      image_valid[a] = 1'b1;
   endtask

   task automatic patch_field(input addr_type a, input logic [NIB_W-1:0] nib,
                              input logic [VAL_W-1:0] operand, input logic sub);
      logic [ACC_W-1:0] acc;
      addr_type         p;
      int               nbytes;
      int               n;
      if (nib != 0) begin
         nbytes = (int'(nib) + 1) / 2;
         acc    = '0;
         for (int i = 0; i < nbytes; i++)
            acc = (acc << 8) | ACC_W'(image_mem[addr_type'(a + i)]);
         acc = sub ? acc - ACC_W'(operand) : acc + ACC_W'(operand);
         acc = acc & ((ACC_W'(1) << (4 * int'(nib))) - ACC_W'(1));
         n   = int'(nib);
         p   = a;
         if (n % 2 == 1) begin
            // odd count: top nibble of the first byte survives
            n--;
            store_byte(p, {image_mem[p][7:4], acc[4 * n +: 4]});
            p = p + 1'b1;
         end
         for (int i = 0; i < n / 2; i++)
            store_byte(addr_type'(p + i), acc[4 * (n - 2 * (i + 1)) +: 8]);
      end
   endtask

   task automatic apply_record(input load_word_type w, output result_word_type r);
      addr_type a;
      r = '0;
      a = addr_type'(32'(section_base) + 32'(w.offset));
      cmd_count[w.cmd]++;
      case (w.cmd)
         CMD_START: begin
            section_base = w.value;
            ref_table[1] = w.value;
            ref_mode     = 1'b0;
         end
         CMD_SETREF: begin
            if (ref_ok(w.ref_index)) begin
               ref_table[w.ref_index] = w.value;
               ref_mode               = 1'b1;
            end else begin
               r.status = STATUS_BAD_REF;
            end
         end
         CMD_WRITE: store_byte(a, w.data_byte);
         CMD_MODIFY: begin
            if (!ref_mode)
               patch_field(a, w.half_bytes, w.value, w.subtract);
            else if (ref_ok(w.ref_index))
               patch_field(a, w.half_bytes, ref_table[w.ref_index], w.subtract);
            else
               r.status = STATUS_BAD_REF;
         end
         CMD_READ: r.read_data = image_mem[addr_type'(w.offset)];
         default: ;
      endcase
   endtask

   // drives one word at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input load_word_type w, input logic fixed,
                            input result_word_type typed_r);
      int              gap;
      result_word_type r;
      gap = src_calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.cmd        <= w.cmd;
      req_if.offset     <= w.offset;
      req_if.data_byte  <= w.data_byte;
      req_if.half_bytes <= w.half_bytes;
      req_if.subtract   <= w.subtract;
      req_if.ref_index  <= w.ref_index;
      req_if.value      <= w.value;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      apply_record(w, r);
      pending_results.push_back(fixed ? typed_r : r);
      words_sent++;
      @(negedge clock);
   endtask

   // text bytes for any covered address not yet loaded, so no read sees unknown memory
   task automatic cover_bytes(input addr_type a, input int n);
      load_word_type w;
      addr_type      p;
      for (int i = 0; i < n; i++) begin
         p = addr_type'(a + i);
         if (!image_valid[p]) begin
            w            = '0;
            w.cmd        = CMD_WRITE;
            w.offset     = OFS_W'(p - addr_type'(section_base));
            w.data_byte  = BYTE_W'($urandom);
            w.half_bytes = NIB_W'($urandom);
            w.ref_index  = REFI_W'($urandom);
            w.value      = VAL_W'($urandom);
            send_word(w, 1'b0, '0);
         end
      end
   endtask

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   task automatic random_record();
      load_word_type w;
      addr_type      a;
      int            pick;
      int            sel;
      w.data_byte  = BYTE_W'($urandom);
      w.half_bytes = NIB_W'($urandom);
      w.subtract   = 1'($urandom);
      w.value      = pick_value();
      w.offset     = ($urandom_range(0, 3) == 0) ? OFS_W'($urandom)
                                                 : OFS_W'($urandom_range(0, 47));
      sel = $urandom_range(0, 9);
      if (sel < 7)
         w.ref_index = REFI_W'($urandom_range(1, REF_ENTRIES - 1));
      else if (sel == 7)
         w.ref_index = '0;
      else
         w.ref_index = REFI_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         w.cmd = CMD_START;
         // bases near the top make patches wrap
         if ($urandom_range(0, 3) == 0)
            w.value = VAL_W'(16'hFFF0 + $urandom_range(0, 15));
      end else if (pick < 18) begin
         w.cmd = CMD_SETREF;
      end else if (pick < 45) begin
         w.cmd = CMD_WRITE;
      end else if (pick < 80) begin
         w.cmd = CMD_MODIFY;
         if ($urandom_range(0, 2) != 0)
            w.half_bytes = NIB_W'($urandom_range(5, 6));
      end else if (pick < 95) begin
         w.cmd = CMD_READ;
         if (recent_addrs.size() != 0 && $urandom_range(0, 3) != 0)
            w.offset = OFS_W'(recent_addrs[$urandom_range(0, recent_addrs.size() - 1)]);
      end else begin
         w.cmd = CMD_W'($urandom_range(CMD_SPARE5, CMD_SPARE7));
      end
      a = addr_type'(32'(section_base) + 32'(w.offset));
      if (w.cmd == CMD_MODIFY)
         cover_bytes(a, (int'(w.half_bytes) + 1) / 2);
      else if (w.cmd == CMD_READ)
         cover_bytes(addr_type'(w.offset), 1);
      else if (w.cmd == CMD_WRITE) begin
         recent_addrs.push_back(a);
         if (recent_addrs.size() > RECENT_MAX)
            void'(recent_addrs.pop_front());
      end
      send_word(w, 1'b0, '0);
   endtask

   // drop valid so the last word is not taken twice while the block drains
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // result side: random stalls, compare against the oldest expectation
   initial begin : sink_side
      int              gap;
      result_word_type want;
      rsp_if.ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         gap = sink_calm ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         if (pending_results.size() == 0) begin
            $error("unexpected result word: status %0d read_data 0x%02h",
                   rsp_if.status, rsp_if.read_data);
            fails++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_if.status);
               fails++;
            end
            if (rsp_if.read_data !== want.read_data) begin
               $error("read_data: expected 0x%02h, got 0x%02h", want.read_data,
                      rsp_if.read_data);
               fails++;
            end
         end
         results_seen++;
         if (results_seen % 40 == 0)
            sink_calm = ($urandom_range(0, 3) == 0);
         @(negedge clock);
      end
   end

   initial begin : source_side
      int iter;
      req_if.valid      = 1'b0;
      req_if.cmd        = '0;
      req_if.offset     = '0;
      req_if.data_byte  = '0;
      req_if.half_bytes = '0;
      req_if.subtract   = 1'b0;
      req_if.ref_index  = '0;
      req_if.value      = '0;
      section_base      = '0;
      ref_mode          = 1'b0;
      foreach (ref_table[i]) ref_table[i] = '0;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++)
         send_word(DIRECTED[i].word, DIRECTED[i].fixed, DIRECTED[i].result);

      iter = 0;
      while (words_sent < N_DIRECTED + RANDOM_WORDS) begin
         if (iter % 50 == 0)
            src_calm = ($urandom_range(0, 3) == 0);
         // let the block run dry now and then
         if (iter % 400 == 200)
            wait_drained();
         random_record();
         iter++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("words: %0d start, %0d set-ref, %0d write, %0d modify, %0d read, %0d unused code",
               cmd_count[CMD_START], cmd_count[CMD_SETREF], cmd_count[CMD_WRITE],
               cmd_count[CMD_MODIFY], cmd_count[CMD_READ],
               cmd_count[CMD_SPARE5] + cmd_count[CMD_SPARE6] + cmd_count[CMD_SPARE7]);
      $display("%0d result words compared, %0d mismatches, %0d cycles", results_seen, fails,
               cycles);
      if (fails == 0 && pending_results.size() == 0)
         $display("** relocating_load_and_patch: PASSED **");
      else
         $display("** relocating_load_and_patch: FAILED **");
      $finish;
   end

endmodule
